@@ rtl/bpsa_pkg.sv @@
// shared types and constants of the block pool slot allocator
// no dependencies; imported by the controller, the datapath and the top level
`default_nettype none

package bpsa_pkg;

   // flat slot space, kept as a bitmap of 64-bit words
   localparam int SLOT_SPACE = 1024;
   localparam int SLOT_W     = 10;
   localparam int POOL_W     = SLOT_W + 1;
   localparam int WORD_BITS  = 64;
   localparam int BIT_IDX_W  = 6;
   localparam int NUM_WORDS  = SLOT_SPACE / WORD_BITS;
   localparam int WORD_IDX_W = 4;
   localparam int STATUS_W   = 3;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_POOL      = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_GROWN     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_RELEASED  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_BAD       = 3'd4;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic scan_clear;
      logic scan_next;
      logic grant_hint;
      logic grant_scan;
      logic grow;
      logic exhaust;
      logic release_ok;
      logic release_bad;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_release;
      logic release_in_pool;
      logic at_last;
      logic hint_ok;
      logic scan_hit;
      logic scan_last;
      logic can_grow;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

@@ rtl/bpsa_ctrl.sv @@
// control state machine of the block pool slot allocator
// depends on bpsa_pkg; drives the datapath through cmd_type, reads sts_type
`default_nettype none

module bpsa_ctrl
   import bpsa_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   output cmd_type      cmd,
   input  wire sts_type sts
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECIDE,
      S_SCAN,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (sts.is_release) begin
               cmd.release_ok  = sts.release_in_pool;
               cmd.release_bad = !sts.release_in_pool;
               state_in        = S_DONE;
            end else if (sts.at_last) begin
               // hint sits on the pool's last slot: grow right away if the block limit allows, else report exhaustion
               cmd.grow    = sts.can_grow;
               cmd.exhaust = !sts.can_grow;
               state_in    = S_DONE;
            end else if (sts.hint_ok) begin
               cmd.grant_hint = 1'b1;
               state_in       = S_DONE;
            end else begin
               cmd.scan_clear = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.scan_hit) begin
               cmd.grant_scan = 1'b1;
               state_in       = S_DONE;
            end else if (sts.scan_last) begin
               cmd.grow    = sts.can_grow;
               cmd.exhaust = !sts.can_grow;
               state_in    = S_DONE;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   // at most one state update per decision
   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.grant_hint, cmd.grant_scan, cmd.grow, cmd.exhaust,
                cmd.release_ok, cmd.release_bad}))
      else $error("more than one action issued in a cycle");

   // a result never overwrites one still waiting
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("result emitted while output register busy");
`endif

endmodule

`default_nettype wire

@@ rtl/bpsa_dp.sv @@
// datapath of the block pool slot allocator: bitmap, pool counters, hint,
// word scanner and output register; depends on bpsa_pkg
`default_nettype none

module bpsa_dp
   import bpsa_pkg::*;
#(
   parameter int SLOTS_PER_BLOCK = 64,
   parameter int MAX_BLOCKS      = 16
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   output sts_type                  sts,
   input  wire logic                req_operation,
   input  wire logic [SLOT_W-1:0]   req_release_slot,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [SLOT_W-1:0]        rsp_granted_slot,
   output logic [STATUS_W-1:0]      rsp_status
);

   localparam int BLOCK_FIT   = SLOT_SPACE / SLOTS_PER_BLOCK;
   localparam int BLOCK_LIMIT = (BLOCK_FIT < MAX_BLOCKS) ? BLOCK_FIT : MAX_BLOCKS;
   localparam int BLK_W       = $clog2(BLOCK_LIMIT + 1);

   logic [WORD_BITS-1:0]  words_ff [NUM_WORDS];
   logic [WORD_BITS-1:0]  words_in [NUM_WORDS];
   logic [BLK_W-1:0]      blocks_ff, blocks_in;
   logic [POOL_W-1:0]     pool_ff, pool_in;
   logic                  hint_valid_ff, hint_valid_in;
   logic [SLOT_W-1:0]     hint_ff, hint_in;
   logic                  op_ff;
   logic [SLOT_W-1:0]     rel_ff;
   logic [WORD_IDX_W-1:0] word_idx_ff, word_idx_in;
   logic [SLOT_W-1:0]     res_slot_ff, res_slot_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic                  rsp_valid_ff;
   logic [SLOT_W-1:0]     rsp_slot_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;

   logic [POOL_W-1:0]     hint_next;
   logic [WORD_BITS-1:0]  rd_word;
   logic [WORD_BITS-1:0]  free_mask;
   logic [BIT_IDX_W-1:0]  free_bit;
   logic                  free_any;
   logic [SLOT_W-1:0]     grant_slot;
   logic                  wr_en;
   logic [SLOT_W-1:0]     wr_slot;
   logic                  wr_val;
   logic                  granting;

   assign hint_next = {1'b0, hint_ff} + POOL_W'(1);
   assign rd_word   = words_ff[word_idx_ff];

   // free slots of the current word that lie inside the grown pool
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         free_mask[b] = !rd_word[b] &&
                        ({1'b0, word_idx_ff, BIT_IDX_W'(b)} < pool_ff);
      end
   end

   // lowest free bit wins
   always_comb begin
      free_bit = '0;
      free_any = 1'b0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (free_mask[b]) begin
            free_bit = BIT_IDX_W'(b);
            free_any = 1'b1;
         end
      end
   end

   always_comb begin
      sts.is_release      = (op_ff == OP_RELEASE);
      sts.release_in_pool = ({1'b0, rel_ff} < pool_ff);
      sts.at_last         = hint_valid_ff && (pool_ff != '0) &&
                            ({1'b0, hint_ff} == pool_ff - POOL_W'(1));
      // word_idx_ff points at the word of the slot after the hint here
      sts.hint_ok         = hint_valid_ff && (hint_next < pool_ff) &&
                            !rd_word[hint_next[BIT_IDX_W-1:0]];
      sts.scan_hit        = free_any;
      sts.scan_last       = ({1'b0, word_idx_ff, BIT_IDX_W'(0)} + POOL_W'(WORD_BITS))
                            >= pool_ff;
      sts.can_grow        = (blocks_ff < BLK_W'(BLOCK_LIMIT));
      sts.out_free        = !rsp_valid_ff || !rsp_stall;
   end

   assign grant_slot = cmd.grant_hint ? hint_next[SLOT_W-1:0] :
                       cmd.grant_scan ? {word_idx_ff, free_bit} :
                                        pool_ff[SLOT_W-1:0];
   assign granting   = cmd.grant_hint || cmd.grant_scan || cmd.grow;

   always_comb begin
      wr_en         = 1'b0;
      wr_slot       = grant_slot;
      wr_val        = 1'b1;
      blocks_in     = blocks_ff;
      pool_in       = pool_ff;
      hint_valid_in = hint_valid_ff;
      hint_in       = hint_ff;
      res_slot_in   = res_slot_ff;
      res_status_in = res_status_ff;
      if (granting) begin
         wr_en         = 1'b1;
         hint_valid_in = 1'b1;
         hint_in       = grant_slot;
         res_slot_in   = grant_slot;
         res_status_in = cmd.grow ? STATUS_GROWN : STATUS_POOL;
      end
      if (cmd.grow) begin
         blocks_in = blocks_ff + BLK_W'(1);
         pool_in   = pool_ff + POOL_W'(SLOTS_PER_BLOCK);
      end
      if (cmd.exhaust) begin
         hint_valid_in = 1'b0;
         hint_in       = '0;
         res_slot_in   = '0;
         res_status_in = STATUS_EXHAUSTED;
      end
      if (cmd.release_ok) begin
         wr_en         = 1'b1;
         wr_slot       = rel_ff;
         wr_val        = 1'b0;
         res_slot_in   = rel_ff;
         res_status_in = STATUS_RELEASED;
      end
      if (cmd.release_bad) begin
         res_slot_in   = rel_ff;
         res_status_in = STATUS_BAD;
      end
   end

   always_comb begin
      for (int w = 0; w < NUM_WORDS; w++) begin
         words_in[w] = words_ff[w];
      end
      if (wr_en) begin
         words_in[wr_slot[SLOT_W-1:BIT_IDX_W]][wr_slot[BIT_IDX_W-1:0]] = wr_val;
      end
   end

   always_comb begin
      word_idx_in = word_idx_ff;
      if (cmd.load) begin
         word_idx_in = hint_next[SLOT_W-1:BIT_IDX_W];
      end else if (cmd.scan_clear) begin
         word_idx_in = '0;
      end else if (cmd.scan_next) begin
         word_idx_in = word_idx_ff + WORD_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < NUM_WORDS; w++) begin
            words_ff[w] <= '0;
         end
         blocks_ff     <= '0;
         pool_ff       <= '0;
         hint_valid_ff <= 1'b0;
         hint_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         for (int w = 0; w < NUM_WORDS; w++) begin
            words_ff[w] <= words_in[w];
         end
         blocks_ff     <= blocks_in;
         pool_ff       <= pool_in;
         hint_valid_ff <= hint_valid_in;
         hint_ff       <= hint_in;
         rsp_valid_ff  <= cmd.emit || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_operation;
         rel_ff <= req_release_slot;
      end
      word_idx_ff   <= word_idx_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      if (cmd.emit) begin
         rsp_slot_ff   <= res_slot_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted_slot = rsp_slot_ff;
   assign rsp_status       = rsp_status_ff;

`ifndef SYNTH
   // pool size tracks the grown block count
   a_pool_size: assert property (@(posedge clock) disable iff (reset)
      pool_ff == POOL_W'(POOL_W'(blocks_ff) * POOL_W'(SLOTS_PER_BLOCK)))
      else $error("pool size out of step with block count");

   // a held hint always points inside the pool
   a_hint_in_pool: assert property (@(posedge clock) disable iff (reset)
      hint_valid_ff |-> ({1'b0, hint_ff} < pool_ff))
      else $error("hint outside grown pool");

   // growth stops at the block limit
   a_block_limit: assert property (@(posedge clock) disable iff (reset)
      blocks_ff <= BLK_W'(BLOCK_LIMIT))
      else $error("block count beyond limit");
`endif

endmodule

`default_nettype wire

@@ rtl/block_pool_slot_allocator.sv @@
// release and hinted allocation pass from the transfer through the decide and done states
// to the output register; an allocation that falls back to first-fit scans the 64-bit
// bitmap words in turn, 1 to 16 of them, before done. one item is in work at a time: the
// next transfer is taken once the result is loaded, which waits on a stalled older result.
// reset is synchronous and clears the bitmap, block count, hint and output at once.
`default_nettype none

module block_pool_slot_allocator
   import bpsa_pkg::*;
#(
   parameter int SLOTS_PER_BLOCK = 64,
   parameter int MAX_BLOCKS      = 16
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_operation,
   input  wire logic [SLOT_W-1:0]   req_release_slot,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [SLOT_W-1:0]        rsp_granted_slot,
   output logic [STATUS_W-1:0]      rsp_status
);

   cmd_type cmd;
   sts_type sts;

   bpsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   bpsa_dp #(
      .SLOTS_PER_BLOCK (SLOTS_PER_BLOCK),
      .MAX_BLOCKS      (MAX_BLOCKS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_operation    (req_operation),
      .req_release_slot (req_release_slot),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_status       (rsp_status)
   );

endmodule

`default_nettype wire
